// ===== rtl/core/dsm_pkg.sv =====
// Shared types, codes and constants of the derailment stage monitor.
package dsm_pkg;

  // Default number of axle slots
  localparam int MAX_AXLES_DEF = 8;

  // Field widths
  localparam int TIMER_W    = 24;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Y/Q limit override: below the threshold the default limit (0.8 in Q4.12) is used
  localparam logic [14:0] YQ_MIN_OVERRIDE = 15'd205;
  localparam logic [15:0] YQ_DEFAULT      = 16'd3277;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ENABLE       = 3'd0;
  localparam logic [2:0] REG_AXLE_COUNT   = 3'd1;
  localparam logic [2:0] REG_YQ_LIMIT     = 3'd2;
  localparam logic [2:0] REG_UNLOAD_LIMIT = 3'd3;
  localparam logic [2:0] REG_DERAIL_DISP  = 3'd4;
  localparam logic [2:0] REG_CLIMB_TIME   = 3'd5;

  // Configuration reset values
  localparam logic       ENABLE_RST     = 1'b1;
  localparam logic [3:0] AXLE_COUNT_RST = 4'd4;

  // Item function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_RESET  = 1'b1;

  // Vehicle derailment stage
  typedef enum logic [2:0] {
    STG_ON_TRACK = 3'd0,
    STG_WARNING  = 3'd1,
    STG_AXLE     = 3'd2,
    STG_BOGIE    = 3'd3,
    STG_VEHICLE  = 3'd4
  } stage_t;

  // Input item: one axle sample or a stage reset
  typedef struct packed {
    logic               func;
    logic [2:0]         axle_index;
    logic               last_axle;
    logic signed [15:0] yq_left;
    logic signed [15:0] right_yq;
    logic signed [15:0] lateral_position;
    logic [15:0]        load_factor;
    logic               shock_unload;
    logic [15:0]        time_step;
  } dsm_in_t;

  // Result item
  typedef struct packed {
    logic       axle_derailed;
    logic       newly_derailed;
    logic [2:0] stage;
    logic [3:0] derailed_total;
  } dsm_out_t;

endpackage

// ===== rtl/core/dsm_ifs.sv =====
// Valid/ready channel interfaces for the input and result items.
interface dsm_in_if;
  import dsm_pkg::*;

  logic    valid;
  logic    ready;
  dsm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dsm_out_if;
  import dsm_pkg::*;

  logic     valid;
  logic     ready;
  dsm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/derailment_stage_monitor.sv =====
// Derailment stage monitor: per-axle flange-climb timers and vehicle derailment stage.
//
// Usage:
//   in_chan  carries one item per handshake: an axle sample (func = sample) or a
//            reset of stage, timers and axle marks (func = reset).
//   out_chan returns exactly one result item per input item, in order.
//   cfg_*    APB-style register port; register i sits at byte address 4*i.
//            Writing axle_count clears timers, axle marks and tick flags.
// Path: an accepted item is held in the input register and then in the result
//   register, from which it is offered on out_chan.
// Throughput: one item per cycle while out_chan is ready; the whole per-axle update
//   and tick close is a single compare/add stage between input and result registers.
// Stall: when out_chan.ready is low the result register holds, and the input
//   register still takes one more item; in_chan.ready drops only when both
//   registers are full.
// Reset: synchronous, active low rst_n; configuration returns to its reset
//   values, stage goes to on track, timers and marks clear, both item
//   registers empty.
module derailment_stage_monitor #(
  parameter int MAX_AXLES = dsm_pkg::MAX_AXLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dsm_in_if.sink                        in_chan,
  dsm_out_if.source                     out_chan,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [dsm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [dsm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [dsm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import dsm_pkg::*;

  localparam logic [4:0] MAX_N = 5'(MAX_AXLES);

  // Configuration registers
  logic         enable_r;
  logic [3:0]   axle_count_r;
  logic [14:0]  yq_limit_r;
  logic [15:0]  unload_limit_r;
  logic [14:0]  derail_disp_r;
  logic [23:0]  climb_time_r;

  // Monitor state
  stage_t                 stage_r, stage_nxt;
  logic [TIMER_W-1:0]     timer_r [MAX_AXLES];
  logic [TIMER_W-1:0]     timer_nxt [MAX_AXLES];
  logic [MAX_AXLES-1:0]   axle_off_r, axle_off_nxt;
  logic [3:0]             off_count_r, off_count_nxt;
  logic                   tick_any_off_r, tick_any_off_nxt;
  logic                   tick_warning_r, tick_warning_nxt;

  // Item registers
  logic     in_q_valid_r;
  dsm_in_t  in_q_r;
  logic     out_valid_r;
  dsm_out_t out_r, out_nxt;

  logic     out_free;
  logic     proc;
  logic     accept;
  logic     cfg_wr;
  logic [2:0] cfg_idx;
  logic     cfg_clear;

  // Datapath signals
  logic [4:0]         n_eff;
  logic [4:0]         half_n;
  logic [15:0]        yq_max;
  logic [15:0]        disp;
  logic [15:0]        load;
  logic [15:0]        limit;
  logic               overloaded;
  logic               unloaded;
  logic               climbing;
  logic [TIMER_W-1:0] sel_timer;
  logic               sel_off;
  logic [TIMER_W:0]   timer_sum;
  logic [16:0]        timer_dec;
  logic [TIMER_W-1:0] timer_upd;
  logic               idx_in_n;
  logic               sample_en;
  logic               any_off;
  logic               newly_nxt;
  logic               derailed_sel;

  // Handshake: result register frees when taken, input register drains into it
  assign out_free      = !out_valid_r || out_chan.ready;
  assign proc          = in_q_valid_r && out_free;
  assign in_chan.ready = !in_q_valid_r || proc;
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  // Configuration port decode
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_clear  = cfg_wr && (cfg_idx == REG_AXLE_COUNT);

  // Read back registers
  always_comb begin
    case (cfg_idx)
      REG_ENABLE:       cfg_prdata = {31'd0, enable_r};
      REG_AXLE_COUNT:   cfg_prdata = {28'd0, axle_count_r};
      REG_YQ_LIMIT:     cfg_prdata = {17'd0, yq_limit_r};
      REG_UNLOAD_LIMIT: cfg_prdata = {16'd0, unload_limit_r};
      REG_DERAIL_DISP:  cfg_prdata = {17'd0, derail_disp_r};
      REG_CLIMB_TIME:   cfg_prdata = {8'd0, climb_time_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= ENABLE_RST;
      axle_count_r   <= AXLE_COUNT_RST;
      yq_limit_r     <= '0;
      unload_limit_r <= '0;
      derail_disp_r  <= '0;
      climb_time_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ENABLE:       enable_r       <= cfg_pwdata[0];
        REG_AXLE_COUNT:   axle_count_r   <= cfg_pwdata[3:0];
        REG_YQ_LIMIT:     yq_limit_r     <= cfg_pwdata[14:0];
        REG_UNLOAD_LIMIT: unload_limit_r <= cfg_pwdata[15:0];
        REG_DERAIL_DISP:  derail_disp_r  <= cfg_pwdata[14:0];
        REG_CLIMB_TIME:   climb_time_r   <= cfg_pwdata[23:0];
        default:          ;
      endcase
    end
  end

  // Effective axle count, clamped to 1..MAX_AXLES, and the bogie threshold
  always_comb begin
    if (axle_count_r == 4'd0) begin
      n_eff = 5'd1;
    end else if ({1'b0, axle_count_r} > MAX_N) begin
      n_eff = MAX_N;
    end else begin
      n_eff = {1'b0, axle_count_r};
    end
    half_n = (n_eff >> 1) == 5'd0 ? 5'd1 : (n_eff >> 1);
  end

  // Per-sample climb conditions
  always_comb begin
    yq_max = ($signed(in_q_r.yq_left) > $signed(in_q_r.right_yq)) ?
             in_q_r.yq_left : in_q_r.right_yq;
    disp   = in_q_r.lateral_position[15] ? (~in_q_r.lateral_position + 16'd1)
                                         : in_q_r.lateral_position;
    load   = in_q_r.shock_unload ? 16'd0 : in_q_r.load_factor;
    limit  = (yq_limit_r >= YQ_MIN_OVERRIDE) ? {1'b0, yq_limit_r} : YQ_DEFAULT;
    overloaded = ($signed(yq_max) > $signed(limit)) &&
                 ({disp, 1'b0} > {2'b00, derail_disp_r});
    unloaded   = (load < unload_limit_r) && (disp > {1'b0, derail_disp_r});
    climbing   = overloaded || unloaded;
  end

  // Select the sampled axle's timer and mark
  always_comb begin
    sel_timer = '0;
    sel_off   = 1'b0;
    for (int i = 0; i < MAX_AXLES; i++) begin
      if (int'(in_q_r.axle_index) == i) begin
        sel_timer = timer_r[i];
        sel_off   = axle_off_r[i];
      end
    end
  end

  // Rise by dt saturating, or fall by 2*dt down to zero
  always_comb begin
    timer_sum = {1'b0, sel_timer} + {{(TIMER_W - 15){1'b0}}, in_q_r.time_step};
    timer_dec = {in_q_r.time_step, 1'b0};
    if (climbing) begin
      timer_upd = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
    end else if (sel_timer > {{(TIMER_W - 17){1'b0}}, timer_dec}) begin
      timer_upd = sel_timer - {{(TIMER_W - 17){1'b0}}, timer_dec};
    end else begin
      timer_upd = '0;
    end
  end

  assign idx_in_n  = {2'b00, in_q_r.axle_index} < n_eff;
  assign sample_en = proc && enable_r && (in_q_r.func == FUNC_SAMPLE) &&
                     (stage_r != STG_VEHICLE);

  // Next state of timers, marks, tick flags and stage
  always_comb begin
    stage_nxt        = stage_r;
    timer_nxt        = timer_r;
    axle_off_nxt     = axle_off_r;
    off_count_nxt    = off_count_r;
    tick_any_off_nxt = tick_any_off_r;
    tick_warning_nxt = tick_warning_r;
    newly_nxt        = 1'b0;
    any_off          = 1'b0;

    if (proc && enable_r && (in_q_r.func == FUNC_RESET)) begin
      // Drop everything back to on track
      stage_nxt        = STG_ON_TRACK;
      timer_nxt        = '{default: '0};
      axle_off_nxt     = '0;
      off_count_nxt    = '0;
      tick_any_off_nxt = 1'b0;
      tick_warning_nxt = 1'b0;
    end else if (sample_en) begin
      // Update the sampled axle
      if (idx_in_n) begin
        if (sel_off) begin
          tick_any_off_nxt = 1'b1;
        end else begin
          for (int i = 0; i < MAX_AXLES; i++) begin
            if (int'(in_q_r.axle_index) == i) begin
              timer_nxt[i] = timer_upd;
              if (timer_upd >= climb_time_r) begin
                axle_off_nxt[i] = 1'b1;
              end
            end
          end
          if (climbing) begin
            tick_warning_nxt = 1'b1;
          end
          if (timer_upd >= climb_time_r) begin
            off_count_nxt    = off_count_r + 4'd1;
            tick_any_off_nxt = 1'b1;
            newly_nxt        = 1'b1;
          end
        end
      end
      // Close the tick: update the vehicle stage
      if (in_q_r.last_axle) begin
        any_off = tick_any_off_nxt || (off_count_nxt != 4'd0);
        if (any_off) begin
          if ({1'b0, off_count_nxt} >= n_eff) begin
            stage_nxt = STG_VEHICLE;
          end else if ({1'b0, off_count_nxt} >= half_n) begin
            stage_nxt = STG_BOGIE;
          end else begin
            stage_nxt = STG_AXLE;
          end
        end else if (tick_warning_nxt) begin
          stage_nxt = STG_WARNING;
        end else if (stage_r == STG_WARNING) begin
          stage_nxt = STG_ON_TRACK;
        end
        tick_any_off_nxt = 1'b0;
        tick_warning_nxt = 1'b0;
      end
    end

    // Axle count write clears the stores, stage kept
    if (cfg_clear) begin
      timer_nxt        = '{default: '0};
      axle_off_nxt     = '0;
      off_count_nxt    = '0;
      tick_any_off_nxt = 1'b0;
      tick_warning_nxt = 1'b0;
    end
  end

  // Build the result item from the updated state
  always_comb begin
    derailed_sel = 1'b0;
    for (int i = 0; i < MAX_AXLES; i++) begin
      if (int'(in_q_r.axle_index) == i) begin
        derailed_sel = axle_off_nxt[i];
      end
    end
    out_nxt.axle_derailed  = derailed_sel;
    out_nxt.newly_derailed = newly_nxt;
    out_nxt.stage          = stage_nxt;
    out_nxt.derailed_total = off_count_nxt;
  end

  // Hold monitor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r        <= STG_ON_TRACK;
      timer_r        <= '{default: '0};
      axle_off_r     <= '0;
      off_count_r    <= '0;
      tick_any_off_r <= 1'b0;
      tick_warning_r <= 1'b0;
    end else begin
      stage_r        <= stage_nxt;
      timer_r        <= timer_nxt;
      axle_off_r     <= axle_off_nxt;
      off_count_r    <= off_count_nxt;
      tick_any_off_r <= tick_any_off_nxt;
      tick_warning_r <= tick_warning_nxt;
    end
  end

  // Advance the item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_q_valid_r <= accept;
      end
      if (out_free) begin
        out_valid_r <= proc;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_q_r <= in_chan.data;
    end
    if (proc) begin
      out_r <= out_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // Derailed count tracks the axle marks
  a_count_matches_marks: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(axle_off_r) == int'(off_count_r))
    else $error("off_count disagrees with axle marks");

  // A newly derailed axle is reported as derailed
  a_newly_implies_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.data.newly_derailed) |-> out_chan.data.axle_derailed)
    else $error("newly derailed axle not marked");

  // Axle count write leaves the stores clear
  a_axle_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_clear |=> (off_count_r == 4'd0) && (axle_off_r == '0) &&
                  !tick_any_off_r && !tick_warning_r)
    else $error("axle count write did not clear the stores");
`endif

endmodule
